// ----- sv/oale_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Shared sizes, operation and status codes, and the command word that the
// controller broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
package oale_pkg;

	localparam int DEPTH       = 8;
	localparam int VALUE_WIDTH = 32;

	// Port field widths.
	localparam int KIND_W = 3;
	localparam int POS_W  = 4;
	localparam int STAT_W = 2;
	localparam int FPOS_W = 3;
	localparam int ELEM_W = 32;
	localparam int CNTO_W = 4;

	// Internal widths derived from the list depth.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_SEARCH = 3'd2,
		KIND_UPDATE = 3'd3,
		KIND_DUMP   = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_POS = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_NONE    = 2'd3
	} status_t;

	typedef logic [VALUE_WIDTH-1:0] word_t;

	// Command seen by every cell in the same cycle.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             upd;
		logic [CMP_W-1:0] pos;
		word_t            data;
	} cell_cmd_t;

endpackage

// ----- sv/oale_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered array list storage cell
// Holds one list entry and compares it with the search key. On insert or
// update it takes the command word at the command position; on insert, the
// lower neighbor's word above it, on remove the upper one's from it upward.
// ----------------------------------------------------------------------------
module oale_cell (
	input  logic                     clk,
	input  oale_pkg::cell_cmd_t      cmd,
	input  logic [oale_pkg::CMP_W-1:0] idx,
	input  oale_pkg::word_t          left_data,
	input  oale_pkg::word_t          right_data,
	input  oale_pkg::word_t          key,
	output oale_pkg::word_t          data,
	output logic                     match
);
	import oale_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		if ((cmd.ins || cmd.upd) && idx == cmd.pos) begin
			data_q <= cmd.data;
		end else if (cmd.ins && idx > cmd.pos) begin
			data_q <= left_data;
		end else if (cmd.rem && idx >= cmd.pos) begin
			data_q <= right_data;
		end
	end

	assign data  = data_q;
	assign match = (data_q == key);

endmodule

// ----- sv/ordered_array_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// Ordered array list engine
// Positional list of signed words held in a row of cells, with insert,
// remove, update, search and dump commands.
// ----------------------------------------------------------------------------
// Usage:
// A command word (kind, position, value) is taken at a rising edge where
// start is high and busy is low. Results come out on status,
// found_position, element, count and last, each valid for exactly one
// cycle while strobe is high; last marks the final result of a command.
// Insert, remove and update shift or write the cells at the accepting edge
// and give their single result in the cycle after acceptance; busy stays
// low, so such commands can be issued every cycle.
// Search and dump walk the cells one position per cycle through a scan
// counter; acceptance registers the scan state and index, and each result
// is registered once more before it appears. Busy is high during the scan
// and drops in the cycle that carries the last result, so the next command
// can be taken at the end of that cycle. A search stops scanning after its
// last match. An empty search or dump answers in the cycle after acceptance.
// Reset clears the entry count and the control state; entry contents are
// not cleared. The receiver cannot stall: every strobed result must be
// taken in its cycle.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [oale_pkg::KIND_W-1:0]       kind,
	input  logic [oale_pkg::POS_W-1:0]        position,
	input  logic signed [31:0]                value,
	output logic                              strobe,
	output logic [oale_pkg::STAT_W-1:0]       status,
	output logic [oale_pkg::FPOS_W-1:0]       found_position,
	output logic signed [oale_pkg::ELEM_W-1:0] element,
	output logic [oale_pkg::CNTO_W-1:0]       count,
	output logic                              last
);
	import oale_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             dump_q, dump_d;
	word_t            key_q, key_d;

	logic             strobe_q, strobe_d;
	status_t          status_q, status_d;
	logic [FPOS_W-1:0] fpos_q, fpos_d;
	logic [ELEM_W-1:0] elem_q, elem_d;
	logic             last_q, last_d;

	cell_cmd_t        cmd;
	word_t            cell_data [DEPTH];
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] later_mask;

	logic             accept;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	word_t            v_ext;
	word_t            scan_word;
	logic             scan_match;
	logic             scan_end;
	logic             more;

	// Row of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_lastc
			assign right_w = cell_data[i];
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end
		oale_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (CMP_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.key        (key_q),
			.data       (cell_data[i]),
			.match      (match_vec[i])
		);
	end

	assign busy    = (state_q == S_SCAN);
	assign accept  = start && !busy;
	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign v_ext   = VALUE_WIDTH'(value);

	assign scan_word  = cell_data[idx_q];
	assign scan_match = match_vec[idx_q];
	assign scan_end   = (CNT_W'(idx_q) == count_q - CNT_W'(1));

	// Matches that still lie ahead of the scan position, inside the list.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			later_mask[i] = (CNT_W'(i) > CNT_W'(idx_q)) && (CNT_W'(i) < count_q);
		end
	end
	assign more = |(match_vec & later_mask);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		dump_d   = dump_q;
		key_d    = key_q;
		cmd      = '0;
		cmd.pos  = pos_ext;
		cmd.data = v_ext;
		strobe_d = 1'b0;
		status_d = STAT_OK;
		fpos_d   = '0;
		elem_d   = '0;
		last_d   = 1'b1;

		if (state_q == S_SCAN) begin
			if (dump_q) begin
				strobe_d = 1'b1;
				fpos_d   = FPOS_W'(idx_q);
				elem_d   = ELEM_W'(scan_word);
				last_d   = scan_end;
				if (scan_end) begin
					state_d = S_IDLE;
				end
			end else if (scan_match) begin
				strobe_d = 1'b1;
				fpos_d   = FPOS_W'(idx_q);
				elem_d   = ELEM_W'(scan_word);
				last_d   = !more;
				if (!more) begin
					state_d = S_IDLE;
				end
			end else if (scan_end) begin
				// Reaching the end without a match means nothing matched.
				strobe_d = 1'b1;
				status_d = STAT_NONE;
				state_d  = S_IDLE;
			end
			idx_d = idx_q + IDX_W'(1);
		end else if (accept) begin
			strobe_d = 1'b1;
			case (kind)
				KIND_INSERT: begin
					if (pos_ext > cnt_ext) begin
						status_d = STAT_BAD_POS;
					end else if (count_q >= CNT_W'(DEPTH)) begin
						status_d = STAT_FULL;
					end else begin
						cmd.ins = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				KIND_REMOVE: begin
					if (pos_ext >= cnt_ext) begin
						status_d = STAT_BAD_POS;
					end else begin
						cmd.rem = 1'b1;
						count_d = count_q - CNT_W'(1);
					end
				end
				KIND_UPDATE: begin
					if (pos_ext >= cnt_ext) begin
						status_d = STAT_BAD_POS;
					end else begin
						cmd.upd = 1'b1;
					end
				end
				KIND_SEARCH, KIND_DUMP: begin
					if (count_q == '0) begin
						status_d = STAT_NONE;
					end else begin
						strobe_d = 1'b0;
						state_d  = S_SCAN;
						idx_d    = '0;
						key_d    = v_ext;
						dump_d   = (kind == KIND_DUMP);
					end
				end
				default: begin
					status_d = STAT_BAD_POS;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		dump_q   <= dump_d;
		key_q    <= key_d;
		status_q <= status_d;
		fpos_q   <= fpos_d;
		elem_q   <= elem_d;
		last_q   <= last_d;
	end

	assign strobe         = strobe_q;
	assign status         = status_q;
	assign found_position = fpos_q;
	assign element        = elem_q;
	assign count          = CNTO_W'(count_q);
	assign last           = last_q;

endmodule
